@@ sv/multiplicative_hash_table_top_macros.svh @@
// ----------------------------------------------------------------------------
// multiplicative hash table assertion macros
// concurrent assertion wrappers clocked on aclk, disabled during reset
// ----------------------------------------------------------------------------
`ifndef MULTIPLICATIVE_HASH_TABLE_TOP_MACROS_SVH
`define MULTIPLICATIVE_HASH_TABLE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define MHT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define MHT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) ante |=> cons) else $error(msg);
`else
`define MHT_ASSERT(lbl, prop, msg)
`define MHT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ sv/mht_pkg.sv @@
// ----------------------------------------------------------------------------
// mht_pkg
// shared constants, codes and types of the multiplicative hash table
// ----------------------------------------------------------------------------
`default_nettype none

package mht_pkg;

    localparam int INDEX_BITS = 8;
    localparam int WAYS       = 4;
    localparam int BUCKETS    = 1 << INDEX_BITS;
    localparam int KEY_W      = 32;
    localparam int DATA_W     = 32;
    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int FILL_W     = $clog2(WAYS + 1);
    localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int REQ_W      = MODE_W + KEY_W + DATA_W;
    localparam int RSP_W      = 1 + DATA_W + STATUS_W;
    localparam int S_TDATA_W  = ((REQ_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((RSP_W + 7) / 8) * 8;

    localparam logic [KEY_W-1:0] HASH_MULT = 32'h9e370001;

    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FIND   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

    typedef logic [INDEX_BITS-1:0] idx_t;
    typedef logic [FILL_W-1:0]     fill_t;
    typedef logic [WAY_W-1:0]      way_t;
    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [DATA_W-1:0]     data_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        key_t              key;
        data_t             value_in;
    } req_t;

    typedef struct packed {
        logic                hit;
        data_t               value_out;
        logic [STATUS_W-1:0] status;
    } rsp_t;

    typedef struct packed {
        fill_t                        fill;
        logic [WAYS-1:0][KEY_W-1:0]   keys;
        logic [WAYS-1:0][DATA_W-1:0]  vals;
    } row_t;

endpackage

`default_nettype wire

@@ sv/mht_bucket_mem.sv @@
// ----------------------------------------------------------------------------
// mht_bucket_mem
// bucket line memory with registered read and per-bucket valid
// flops so that an unwritten bucket reads back with an empty fill count
// ----------------------------------------------------------------------------
`default_nettype none
`include "multiplicative_hash_table_top_macros.svh"

module mht_bucket_mem (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          rd_en,
    input  wire mht_pkg::idx_t rd_addr,
    output mht_pkg::row_t      rd_row,
    input  wire logic          wr_en,
    input  wire mht_pkg::idx_t wr_addr,
    input  wire mht_pkg::row_t wr_row
);
    import mht_pkg::*;

    row_t               mem [BUCKETS];
    logic [BUCKETS-1:0] valid_reg;
    row_t               rd_data_reg;
    logic               rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_row;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_comb begin
        rd_row = rd_data_reg;
        if (!rd_valid_reg) begin
            rd_row.fill = '0;
        end
    end

    `MHT_ASSERT(a_no_rw_overlap, !(rd_en && wr_en), "bucket read and write in one cycle")
    `MHT_ASSERT(a_fill_bound, wr_en |-> wr_row.fill <= FILL_W'(WAYS), "fill count over ways")

endmodule

`default_nettype wire

@@ sv/mht_update.sv @@
// ----------------------------------------------------------------------------
// mht_update
// compares all ways of one bucket line and builds the written-back line
// and the response for add, find and remove
// ----------------------------------------------------------------------------
`default_nettype none

module mht_update (
    input  wire mht_pkg::req_t req,
    input  wire mht_pkg::row_t row_in,
    output mht_pkg::row_t  row_out,
    output logic           wr_en,
    output mht_pkg::rsp_t  rsp
);
    import mht_pkg::*;

    fill_t           n;
    logic [WAYS-1:0] match;
    logic            found;
    way_t            fw;
    data_t           found_val;

    always_comb begin
        n = (row_in.fill > FILL_W'(WAYS)) ? FILL_W'(WAYS) : row_in.fill;
        for (int w = 0; w < WAYS; w++) begin
            match[w] = (FILL_W'(w) < n) && (row_in.keys[w] == req.key);
        end
        found = 1'b0;
        fw    = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                found = 1'b1;
                fw    = WAY_W'(w);
            end
        end
        found_val = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (WAY_W'(w) == fw) begin
                found_val = row_in.vals[w];
            end
        end
    end

    always_comb begin
        row_out       = row_in;
        wr_en         = 1'b0;
        rsp.hit       = 1'b0;
        rsp.value_out = '0;
        rsp.status    = ST_OK;
        case (req.mode)
            MODE_ADD: begin
                if (n >= FILL_W'(WAYS)) begin
                    rsp.status = ST_FULL;
                end else begin
                    for (int w = 0; w < WAYS; w++) begin
                        if (FILL_W'(w) == n) begin
                            row_out.keys[w] = req.key;
                            row_out.vals[w] = req.value_in;
                        end
                    end
                    row_out.fill = n + FILL_W'(1);
                    wr_en        = 1'b1;
                end
            end
            MODE_FIND: begin
                if (found) begin
                    rsp.hit       = 1'b1;
                    rsp.value_out = found_val;
                end else begin
                    rsp.status = ST_MISS;
                end
            end
            MODE_REMOVE: begin
                if (found) begin
                    for (int w = 0; w < WAYS - 1; w++) begin
                        if (WAY_W'(w) >= fw) begin
                            row_out.keys[w] = row_in.keys[w+1];
                            row_out.vals[w] = row_in.vals[w+1];
                        end
                    end
                    row_out.fill = n - FILL_W'(1);
                    wr_en        = 1'b1;
                    rsp.hit      = 1'b1;
                end else begin
                    rsp.status = ST_MISS;
                end
            end
            default: begin
                rsp.status = ST_OK;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/multiplicative_hash_table_top.sv @@
// ----------------------------------------------------------------------------
// multiplicative_hash_table_top
// key to data table hashed by the top index bits of key * 0x9e370001,
// fixed-depth buckets kept in insertion order in one line-wide memory
//
//   channel   direction  tdata fields (low bit first)
//   s_axis    in         mode[1:0], key[33:2], value_in[65:34]
//   m_axis    out        hit[0], value_out[32:1], status[34:33]
//
// for each request the bucket line is read on accept, then
// compared, written back and the response registered in the next cycle
// bucket fill counts read as empty after reset via per-bucket valid flops,
// so no clearing pass is needed
// a response waiting in the output register holds off new requests; the
// next request is taken only in the cycle that the response is taken
// ----------------------------------------------------------------------------
`default_nettype none
`include "multiplicative_hash_table_top_macros.svh"

module multiplicative_hash_table_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // mode, key, value_in
    input  wire logic [mht_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // hit, value_out, status
    output logic [mht_pkg::M_TDATA_W-1:0]      m_tdata
);
    import mht_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_UPD  = 1'b1;

    logic state_reg;
    logic state_next;
    req_t req_reg;
    idx_t idx_reg;
    rsp_t rsp_reg;
    logic m_tvalid_reg;

    req_t        s_req;
    logic [KEY_W-1:0] prod;
    idx_t        hash_idx;
    logic        accept;
    row_t        rd_row;
    row_t        wr_row;
    logic        upd_we;
    logic        mem_we;
    rsp_t        upd_rsp;

    assign s_req.mode     = s_tdata[MODE_W-1:0];
    assign s_req.key      = s_tdata[MODE_W+KEY_W-1:MODE_W];
    assign s_req.value_in = s_tdata[REQ_W-1:MODE_W+KEY_W];

    assign prod     = $unsigned(s_req.key) * HASH_MULT;
    assign hash_idx = prod[KEY_W-1 -: INDEX_BITS];

    assign s_tready = (state_reg == S_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign mem_we   = (state_reg == S_UPD) && upd_we;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_UPD;
                end
            end
            S_UPD: begin
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_UPD) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= s_req;
            idx_reg <= hash_idx;
        end
        if (state_reg == S_UPD) begin
            rsp_reg <= upd_rsp;
        end
    end

    mht_bucket_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (hash_idx),
        .rd_row  (rd_row),
        .wr_en   (mem_we),
        .wr_addr (idx_reg),
        .wr_row  (wr_row)
    );

    mht_update u_upd (
        .req     (req_reg),
        .row_in  (rd_row),
        .row_out (wr_row),
        .wr_en   (upd_we),
        .rsp     (upd_rsp)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-RSP_W){1'b0}}, rsp_reg.status,
                       rsp_reg.value_out, rsp_reg.hit};

    `MHT_ASSERT_NEXT(a_rsp_latency, accept, ##1 m_tvalid, "no response two cycles after request")
    `MHT_ASSERT(a_hit_ok, m_tvalid && rsp_reg.hit |-> rsp_reg.status == ST_OK, "hit with bad status")
    `MHT_ASSERT(a_miss_zero, m_tvalid && !rsp_reg.hit |-> rsp_reg.value_out == '0, "data without hit")

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// multiplicative hash table testbench
// drives add, find, remove and no-op requests over the stream input, predicts
// each response from a local copy of the bucket table and checks every
// response field by field; directed corner cases first, then random traffic
// focused on a few hot buckets so chains fill, overflow and shift on removal
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import mht_pkg::*;

    localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;
    localparam int SLOTS       = BUCKETS * WAYS;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES      = 11;
    localparam int PHASE_ITEMS = 150;
    localparam int HOT_KEYS    = 15;

    typedef struct {
        logic [MODE_W-1:0] mode;
        key_t              key;
        data_t             value;
        bit                drain;
    } request_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    request_t request_queue[$];
    rsp_t     expected_rsp[$];
    int       bucket_count[BUCKETS];
    key_t     slot_key[SLOTS];
    data_t    slot_data[SLOTS];
    key_t     hot_keys[HOT_KEYS];

    int mismatch_count = 0;
    int n_accepted = 0;
    int cycle_count = 0;
    bit s_taken = 1'b0;
    int burst_left = 1;
    int gap_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int ready_pct = 100;
    int pattern_left = 0;

    multiplicative_hash_table_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic idx_t hash_bucket(key_t key);
        logic [KEY_W-1:0] prod;
        prod = $unsigned(key) * HASH_MULT;
        return prod[KEY_W-1 -: INDEX_BITS];
    endfunction

    // applies one request to the local table and returns its response
    function automatic rsp_t table_apply(logic [MODE_W-1:0] mode, key_t key, data_t value);
        rsp_t  r;
        idx_t  b;
        int    n;
        int    base;
        int    w;
        b = hash_bucket(key);
        n = bucket_count[b];
        base = int'(b) * WAYS;
        w = -1;
        r.hit = 1'b0;
        r.value_out = '0;
        r.status = ST_OK;
        for (int i = 0; i < n; i++) begin
            if (w < 0 && slot_key[base + i] == key)
                w = i;
        end
        case (mode)
            MODE_ADD: begin
                if (n >= WAYS) begin
                    r.status = ST_FULL;
                end else begin
                    slot_key[base + n] = key;
                    slot_data[base + n] = value;
                    bucket_count[b] = n + 1;
                end
            end
            MODE_FIND: begin
                if (w >= 0) begin
                    r.hit = 1'b1;
                    r.value_out = slot_data[base + w];
                end else begin
                    r.status = ST_MISS;
                end
            end
            MODE_REMOVE: begin
                if (w >= 0) begin
                    for (int i = w; i + 1 < n; i++) begin
                        slot_key[base + i] = slot_key[base + i + 1];
                        slot_data[base + i] = slot_data[base + i + 1];
                    end
                    bucket_count[b] = n - 1;
                    r.hit = 1'b1;
                end else begin
                    r.status = ST_MISS;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic key_t key_in_bucket(idx_t b);
        key_t k;
        k = key_t'($urandom);
        while (hash_bucket(k) != b)
            k = key_t'($urandom);
        return k;
    endfunction

    task automatic queue_request(logic [MODE_W-1:0] mode, key_t key, data_t value,
                                 bit drain = 1'b0);
        request_t it;
        it.mode = mode;
        it.key = key;
        it.value = value;
        it.drain = drain;
        request_queue.push_back(it);
    endtask

    task automatic report_mismatch(string msg);
        if (mismatch_count < 50)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // driver: bursts of requests with random gaps, changes at the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_taken) begin
            s_tvalid <= 1'b1;
        end else if (gap_left > 0) begin
            s_tvalid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (request_queue.size() == 0) begin
            s_tvalid <= 1'b0;
        end else if (request_queue[0].drain && expected_rsp.size() != 0) begin
            s_tvalid <= 1'b0;
        end else begin
            s_tvalid <= 1'b1;
            s_tdata <= {{(S_TDATA_W - REQ_W){1'b0}}, request_queue[0].value,
                        request_queue[0].key, request_queue[0].mode};
            void'(request_queue.pop_front());
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 20);
                gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
                burst_left <= burst_left - 1;
            end
        end
    end

    // receiver: random ready pattern plus one long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_accepted >= HOLD_AT) begin
            m_tready <= 1'b0;
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end else begin
            if (pattern_left == 0) begin
                pattern_left <= $urandom_range(20, 80);
                case ($urandom_range(0, 3))
                    0: ready_pct <= 100;
                    1: ready_pct <= 80;
                    2: ready_pct <= 50;
                    default: ready_pct <= 20;
                endcase
            end else begin
                pattern_left <= pattern_left - 1;
            end
            m_tready <= ($urandom_range(0, 99) < ready_pct);
        end
    end

    // monitor: checks responses, then predicts accepted requests
    always @(posedge aclk) begin
        rsp_t want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
        if (!aresetn) begin
            s_taken <= 1'b0;
        end else begin
            s_taken <= s_tvalid && s_tready;
            if (m_tvalid && m_tready) begin
                if (expected_rsp.size() == 0) begin
                    report_mismatch($sformatf("unexpected response %h", m_tdata));
                end else begin
                    want = expected_rsp.pop_front();
                    if (m_tdata[0] !== want.hit)
                        report_mismatch($sformatf("hit %b, want %b", m_tdata[0], want.hit));
                    if (m_tdata[32:1] !== want.value_out)
                        report_mismatch($sformatf("value_out %h, want %h",
                                                  m_tdata[32:1], want.value_out));
                    if (m_tdata[34:33] !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  m_tdata[34:33], want.status));
                end
            end
            if (s_tvalid && s_tready) begin
                expected_rsp.push_back(table_apply(s_tdata[1:0], key_t'(s_tdata[33:2]),
                                                   s_tdata[65:34]));
                n_accepted <= n_accepted + 1;
            end
        end
    end

    initial begin
        key_t  k0;
        key_t  k1;
        key_t  k2;
        key_t  k;
        data_t v;
        int    r;
        for (int i = 0; i < BUCKETS; i++)
            bucket_count[i] = 0;

        // directed corner cases
        k0 = 32'h12345678;
        k1 = key_in_bucket(hash_bucket(k0));
        k2 = key_in_bucket(hash_bucket(k0));
        queue_request(MODE_FIND, 32'sd0, 32'h0);
        queue_request(MODE_REMOVE, 32'sd0, 32'hffffffff);
        queue_request(MODE_ADD, 32'h80000000, 32'hffffffff);
        queue_request(MODE_ADD, 32'h7fffffff, 32'h0);
        queue_request(MODE_ADD, -32'sd1, 32'ha5a5a5a5);
        queue_request(MODE_FIND, 32'h80000000, 32'h0);
        queue_request(MODE_FIND, 32'h7fffffff, 32'hffffffff);
        queue_request(MODE_FIND, -32'sd1, 32'h0);
        queue_request(MODE_ADD, k0, 32'h1);
        queue_request(MODE_ADD, k1, 32'h2);
        queue_request(MODE_ADD, k0, 32'h3);
        queue_request(MODE_ADD, k2, 32'h4);
        queue_request(MODE_ADD, k1, 32'h5);
        queue_request(MODE_FIND, k0, 32'h0);
        queue_request(MODE_REMOVE, k1, 32'h0);
        queue_request(MODE_FIND, k1, 32'h0);
        queue_request(MODE_REMOVE, k0, 32'h0);
        queue_request(MODE_FIND, k0, 32'h0);
        queue_request(MODE_FIND, k2, 32'h0);
        queue_request(MODE_NOP, k2, 32'h5a5a5a5a);
        queue_request(MODE_REMOVE, 32'h80000000, 32'h0);
        queue_request(MODE_FIND, 32'h80000000, 32'h0);

        // random traffic, each phase hammering a few hot buckets
        for (int p = 0; p < PHASES; p++) begin
            for (int h = 0; h < HOT_KEYS; h += 5) begin
                k = key_t'($urandom);
                for (int j = 0; j < 5; j++)
                    hot_keys[h + j] = key_in_bucket(hash_bucket(k));
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                k = ($urandom_range(0, 3) == 0) ? key_t'($urandom)
                                                 : hot_keys[$urandom_range(0, HOT_KEYS - 1)];
                case ($urandom_range(0, 19))
                    0: v = 32'h0;
                    1: v = 32'hffffffff;
                    default: v = $urandom;
                endcase
                r = $urandom_range(0, 99);
                queue_request((r < 40) ? MODE_ADD : (r < 70) ? MODE_FIND :
                              (r < 97) ? MODE_REMOVE : MODE_NOP,
                              k, v, (i == 0 && (p == 0 || p == 5)));
            end
        end

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (request_queue.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (expected_rsp.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (expected_rsp.size() != 0)
            report_mismatch($sformatf("%0d responses missing", expected_rsp.size()));
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
